// File: rtl/core/assert_macros.svh
// Assertion macros shared by the core RTL.
// Depends on nothing; simulation sees the checks, synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check an expression at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLY(lbl, clk, rst_n, cond, cons)

`endif

`endif

// File: rtl/core/sps_pkg.sv
// Shared constants and types of the scored position set core.
// No dependencies; used by scored_position_set_core.
package sps_pkg;

    localparam int POSITIONS  = 256;
    localparam int SCORE_BITS = 32;
    localparam int IDX_W      = $clog2(POSITIONS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int FUNC_W     = 3;
    localparam int POS_W      = 8;
    localparam int INDEX_W    = 8;
    localparam int SCORE_W    = 32;
    localparam int STATUS_W   = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR  = 3'd0,
        FN_INSERT = 3'd1,
        FN_REMOVE = 3'd2,
        FN_FIND   = 3'd3,
        FN_SORT   = 3'd4,
        FN_SWAP   = 3'd5,
        FN_READ   = 3'd6
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE    = 2'd0,
        STAT_IGNORED = 2'd1,
        STAT_RANGE   = 2'd2
    } t_status;

    // One list entry as held in the entry memory
    typedef struct packed {
        logic [IDX_W-1:0]      pos;
        logic [SCORE_BITS-1:0] score;
    } t_entry;

    // One result transaction
    typedef struct packed {
        logic                found;
        logic [POS_W-1:0]    pos_out;
        logic [SCORE_W-1:0]  score_out;
        logic [CNT_W-1:0]    count;
        t_status             status;
    } t_result;

endpackage

// File: rtl/core/scored_position_set_core.sv
// Scored position set: list of (position, score) entries in one memory,
// membership bitmap and entry count in flip-flops. Depends on sps_pkg and
// assert_macros.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one command transaction:
//   func, pos, score, index_a, index_b. Output channel (o_out_valid /
//   i_out_ready) returns exactly one result transaction per command, in order.
//   Steps from acceptance to the result register, set by the single write
//   port and the registered read data of the entry memory:
//     clear, insert, find, unused code, bad index: done at acceptance
//     read: one memory read      swap: two reads, one memory write per entry
//     remove: scan from entry zero to the match (one entry read a cycle), then
//           overwrite the match with the last entry; sort: insertion sort, each
//           key shifting lower-scored entries right (fewer than two: at acceptance)
//   One command is in flight at a time; o_in_ready is high again once the
//   result sits in the output register, so the next command is taken while
//   that result waits. If the receiver stalls and the output register is
//   still full when a result completes, the result is parked and moves in
//   at the edge where the waiting result is taken.
//   Reset (i_rst_n low, synchronous) empties the bitmap and the count and
//   drops any pending result; entry memory contents are not cleared.
module scored_position_set_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [sps_pkg::FUNC_W-1:0]          i_func,
    input  logic [sps_pkg::POS_W-1:0]           i_pos,
    input  logic signed [sps_pkg::SCORE_W-1:0]  i_score,
    input  logic [sps_pkg::INDEX_W-1:0]         i_index_a,
    input  logic [sps_pkg::INDEX_W-1:0]         i_index_b,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_found,
    output logic [sps_pkg::POS_W-1:0]           o_pos_out,
    output logic signed [sps_pkg::SCORE_W-1:0]  o_score_out,
    output logic [sps_pkg::CNT_W-1:0]           o_count,
    output logic [sps_pkg::STATUS_W-1:0]        o_status
);

    localparam int IDX_W      = sps_pkg::IDX_W;
    localparam int CNT_W      = sps_pkg::CNT_W;
    localparam int POSITIONS  = sps_pkg::POSITIONS;
    localparam int SCORE_BITS = sps_pkg::SCORE_BITS;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_READ  = 9'b000000010,
        S_SWAP1 = 9'b000000100,
        S_SWAP2 = 9'b000001000,
        S_SCAN  = 9'b000010000,
        S_KEY   = 9'b000100000,
        S_CMP   = 9'b001000000,
        S_PLACE = 9'b010000000,
        S_HOLD  = 9'b100000000
    } t_state;

    // Control state
    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [POSITIONS-1:0]   r_member, n_member;
    logic                   r_out_valid;

    // Payload and work registers
    logic [IDX_W-1:0]       r_pos, r_ia, r_ib;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [IDX_W-1:0]       r_j, n_j;
    logic [CNT_W-1:0]       r_i, n_i;
    sps_pkg::t_entry        r_key, n_key;
    sps_pkg::t_result       r_res, n_res, r_out, out_data;

    // Entry memory, two read ports and one write port
    sps_pkg::t_entry        r_mem [POSITIONS];
    sps_pkg::t_entry        r_rd_a, r_rd_b, wdata;
    logic [IDX_W-1:0]       raddr_a, raddr_b, waddr;
    logic                   re_a, re_b, we;

    logic                   in_acc, out_free, fin, ld;
    logic                   ia_bad, ib_bad;
    logic [IDX_W-1:0]       in_pos;
    logic [CNT_W-1:0]       i_next;
    sps_pkg::t_func         in_func;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign in_func     = sps_pkg::t_func'(i_func);
    assign in_pos      = IDX_W'(i_pos);
    assign ia_bad      = CNT_W'(i_index_a) >= r_count;
    assign ib_bad      = CNT_W'(i_index_b) >= r_count;
    assign i_next      = r_i + 1'b1;

    // Decode the command and step the multi-cycle operations
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_member = r_member;
        n_idx    = r_idx;
        n_i      = r_i;
        n_j      = r_j;
        n_key    = r_key;
        we       = 1'b0;
        waddr    = '0;
        wdata    = '0;
        re_a     = 1'b0;
        re_b     = 1'b0;
        raddr_a  = '0;
        raddr_b  = '0;
        fin      = 1'b0;
        ld       = 1'b0;
        n_res    = '0;
        out_data = r_res;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (in_func)
                        sps_pkg::FN_CLEAR: begin
                            n_member = '0;
                            n_count  = '0;
                            fin      = 1'b1;
                        end
                        sps_pkg::FN_INSERT: begin
                            fin = 1'b1;
                            if (r_member[in_pos]) begin
                                n_res.found  = 1'b1;
                                n_res.status = sps_pkg::STAT_IGNORED;
                            end else if (r_count < CNT_W'(POSITIONS)) begin
                                we                = 1'b1;
                                waddr             = r_count[IDX_W-1:0];
                                wdata.pos         = in_pos;
                                wdata.score       = SCORE_BITS'(i_score);
                                n_member[in_pos]  = 1'b1;
                                n_count           = r_count + 1'b1;
                                n_res.found       = 1'b1;
                            end
                        end
                        sps_pkg::FN_REMOVE: begin
                            if (!r_member[in_pos]) begin
                                fin          = 1'b1;
                                n_res.status = sps_pkg::STAT_IGNORED;
                            end else begin
                                // Start the scan at entry zero, fetch the last entry
                                n_member[in_pos] = 1'b0;
                                re_a             = 1'b1;
                                raddr_a          = '0;
                                re_b             = 1'b1;
                                raddr_b          = IDX_W'(r_count - 1'b1);
                                n_idx            = '0;
                                n_state          = S_SCAN;
                            end
                        end
                        sps_pkg::FN_FIND: begin
                            fin         = 1'b1;
                            n_res.found = r_member[in_pos];
                        end
                        sps_pkg::FN_SORT: begin
                            if (r_count < CNT_W'(2)) begin
                                fin = 1'b1;
                            end else begin
                                re_a    = 1'b1;
                                raddr_a = IDX_W'(1);
                                n_i     = CNT_W'(1);
                                n_state = S_KEY;
                            end
                        end
                        sps_pkg::FN_SWAP: begin
                            if (ia_bad || ib_bad) begin
                                fin          = 1'b1;
                                n_res.status = sps_pkg::STAT_RANGE;
                            end else begin
                                re_a    = 1'b1;
                                raddr_a = IDX_W'(i_index_a);
                                re_b    = 1'b1;
                                raddr_b = IDX_W'(i_index_b);
                                n_state = S_SWAP1;
                            end
                        end
                        sps_pkg::FN_READ: begin
                            if (ia_bad) begin
                                fin          = 1'b1;
                                n_res.status = sps_pkg::STAT_RANGE;
                            end else begin
                                re_a    = 1'b1;
                                raddr_a = IDX_W'(i_index_a);
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                fin             = 1'b1;
                n_res.pos_out   = sps_pkg::POS_W'(r_rd_a.pos);
                n_res.score_out = sps_pkg::SCORE_W'($signed(r_rd_a.score));
            end
            S_SWAP1: begin
                we      = 1'b1;
                waddr   = r_ia;
                wdata   = r_rd_b;
                n_state = S_SWAP2;
            end
            S_SWAP2: begin
                we    = 1'b1;
                waddr = r_ib;
                wdata = r_rd_a;
                fin   = 1'b1;
            end
            S_SCAN: begin
                // Overwrite the match with the last entry, else read on
                if (r_rd_a.pos == r_pos || CNT_W'(r_idx) == r_count - 1'b1) begin
                    we      = 1'b1;
                    waddr   = r_idx;
                    wdata   = r_rd_b;
                    n_count = r_count - 1'b1;
                    fin     = 1'b1;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    re_a    = 1'b1;
                    raddr_a = r_idx + 1'b1;
                end
            end
            S_KEY: begin
                // Latch the key and fetch its left neighbor
                n_key   = r_rd_a;
                n_j     = r_i[IDX_W-1:0];
                re_a    = 1'b1;
                raddr_a = IDX_W'(r_i - 1'b1);
                n_state = S_CMP;
            end
            S_CMP: begin
                if ($signed(r_rd_a.score) < $signed(r_key.score)) begin
                    // Shift the neighbor right into the hole
                    we    = 1'b1;
                    waddr = r_j;
                    wdata = r_rd_a;
                    n_j   = r_j - 1'b1;
                    if (r_j == IDX_W'(1)) begin
                        n_state = S_PLACE;
                    end else begin
                        re_a    = 1'b1;
                        raddr_a = r_j - IDX_W'(2);
                    end
                end else begin
                    // Drop the key into the hole and fetch the next key
                    we    = 1'b1;
                    waddr = r_j;
                    wdata = r_key;
                    n_i   = i_next;
                    if (i_next >= r_count) begin
                        fin = 1'b1;
                    end else begin
                        re_a    = 1'b1;
                        raddr_a = i_next[IDX_W-1:0];
                        n_state = S_KEY;
                    end
                end
            end
            S_PLACE: begin
                we    = 1'b1;
                waddr = r_j;
                wdata = r_key;
                n_i   = i_next;
                if (i_next >= r_count) begin
                    fin = 1'b1;
                end else begin
                    re_a    = 1'b1;
                    raddr_a = i_next[IDX_W-1:0];
                    n_state = S_KEY;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    ld       = 1'b1;
                    out_data = r_res;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_res.count = n_count;

        // Hand the result to the output register, or park it
        if (fin) begin
            if (out_free) begin
                ld       = 1'b1;
                out_data = n_res;
                n_state  = S_IDLE;
            end else begin
                n_state = S_HOLD;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_member    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_member    <= n_member;
            r_out_valid <= ld || (r_out_valid && !i_out_ready);
        end
    end

    // Payload and work registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pos <= in_pos;
            r_ia  <= IDX_W'(i_index_a);
            r_ib  <= IDX_W'(i_index_b);
        end
        if (fin && !out_free) begin
            r_res <= n_res;
        end
        if (ld) begin
            r_out <= out_data;
        end
        r_idx <= n_idx;
        r_i   <= n_i;
        r_j   <= n_j;
        r_key <= n_key;
    end

    // Entry memory with registered read data
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re_a) begin
            r_rd_a <= r_mem[raddr_a];
        end
        if (re_b) begin
            r_rd_b <= r_mem[raddr_b];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out.found;
    assign o_pos_out   = r_out.pos_out;
    assign o_score_out = r_out.score_out;
    assign o_count     = r_out.count;
    assign o_status    = r_out.status;

    `include "assert_macros.svh"

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(POSITIONS))
    `ASSERT_IMPLY(a_map_matches_count, i_clk, i_rst_n, r_state == S_IDLE, $countones(r_member) == 32'(r_count))
    `ASSERT_IMPLY(a_scan_in_list, i_clk, i_rst_n, r_state == S_SCAN, CNT_W'(r_idx) < r_count)
    `ASSERT_IMPLY(a_hole_left_of_key, i_clk, i_rst_n, r_state == S_CMP, CNT_W'(r_j) <= r_i)

endmodule
